@@ sv/mwc_pkg.sv @@
package mwc_pkg;

  // widths that the parameter range of the sample store settles
  localparam int CNT_W            = 5;    // holds a set size up to 31
  localparam int DEF_MAX_SAMPLES  = 11;
  localparam int JOBQ_DEPTH       = 2;

  // word fields
  localparam int SAMPLE_W = 24;
  localparam int TEMP_W   = 16;
  localparam int WCG_W    = 15;
  localparam int HELD_W   = 19;

  // register indexes on the config port
  localparam logic [2:0] CFG_DRIFT      = 3'd0;
  localparam logic [2:0] CFG_CAL_TEMP   = 3'd1;
  localparam logic [2:0] CFG_SPREAD_LIM = 3'd2;
  localparam logic [2:0] CFG_MIN_SAMP   = 3'd3;
  localparam logic [2:0] CFG_HALF_MODE  = 3'd4;

  // register reset values
  localparam logic [15:0]        RST_DRIFT      = 16'd1500;
  localparam logic signed [14:0] RST_CAL_TEMP   = 15'sd2000;
  localparam logic [15:0]        RST_SPREAD_LIM = 16'd350;
  localparam logic [3:0]         RST_MIN_SAMP   = 4'd5;

  // report status codes
  localparam logic [1:0] ST_FRESH    = 2'd0;
  localparam logic [1:0] ST_UNSTABLE = 2'd1;
  localparam logic [1:0] ST_FEW      = 2'd2;
  localparam logic [1:0] ST_NONE     = 2'd3;

  // temperature window, exclusive, hundredths of a degree
  localparam logic signed [TEMP_W-1:0] T_LOW  = -16'sd5500;
  localparam logic signed [TEMP_W-1:0] T_HIGH = 16'sd12500;

  // compensation is worked in 1e-5 g; grams come out of a reciprocal multiply
  localparam int UNIT_G  = 100000;
  localparam int Q_W     = 17;
  localparam int Q_BIAS  = 1 << (Q_W - 1);
  localparam int REM_W   = 34;
  localparam logic [REM_W+1:0] DIV_BASE =
    (REM_W+2)'(Q_BIAS) * (REM_W+2)'(UNIT_G) + (REM_W+2)'(UNIT_G / 2);
  localparam logic [HELD_W-1:0] W_MAX_G = 19'd320000;

  // UNIT_G is 3125 << 5; floor divide by 3125 as multiply and shift, exact below 2**29
  localparam int          UNIT_SH    = 5;
  localparam int          RECIP_SH   = 41;
  localparam logic [29:0] RECIP3125  = 30'd703687442;

  // divide by ten as multiply and shift, exact below 2**22
  localparam int          RECIP10_SH = 23;
  localparam logic [19:0] RECIP10    = 20'd838861;

  typedef struct packed {
    logic [CNT_W-1:0]         n;
    logic signed [TEMP_W-1:0] temp_x100;
    logic                     temp_present;
  } job_t;

  typedef struct packed {
    logic [15:0]        drift_mg;
    logic signed [14:0] cal_temp;
    logic [15:0]        spread_limit;
    logic [3:0]         min_samples;
    logic               half_mode;
  } cfg_t;

  typedef struct packed {
    logic walking;
  } bk_stat_t;

endpackage

@@ sv/mwc_jobq.sv @@
module mwc_jobq #(
  parameter int DEPTH = mwc_pkg::JOBQ_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  mwc_pkg::job_t push_job,
  input  logic          pop,
  output mwc_pkg::job_t head,
  output logic          empty
);
  import mwc_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          entry_r [DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [CW-1:0] count_r;

  assign empty = (count_r == '0);
  assign head  = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

@@ sv/mwc_front.sv @@
module mwc_front #(
  parameter int MAX_SAMPLES = mwc_pkg::DEF_MAX_SAMPLES
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [39:0]                    in_tdata,   // sample_g, temp_x100
  input  logic [1:0]                     in_tuser,   // sample_ok, temp_present
  input  logic                           in_tlast,
  input  mwc_pkg::bk_stat_t              stat,
  input  logic                           q_empty,
  output logic                           q_push,
  output mwc_pkg::job_t                  q_job,
  input  logic [$clog2(MAX_SAMPLES)-1:0] rd_addr,
  output logic [mwc_pkg::SAMPLE_W-1:0]   rd_data
);
  import mwc_pkg::*;

  localparam int IDX_W = $clog2(MAX_SAMPLES);

  logic [SAMPLE_W-1:0] store_r [MAX_SAMPLES];
  logic [SAMPLE_W-1:0] rd_data_r;
  logic [CNT_W-1:0]    cnt_r;
  logic                acc;
  logic                wr;

  // the store is shared with the back end, so a new set waits while a job is queued and until the walk is over
  assign in_tready = q_empty && !stat.walking;
  assign acc       = in_tvalid && in_tready;
  assign wr        = in_tuser[0] && (cnt_r < CNT_W'(MAX_SAMPLES));

  assign q_push             = acc && in_tlast;
  assign q_job.n            = wr ? cnt_r + 1'b1 : cnt_r;
  assign q_job.temp_x100    = in_tdata[39:24];
  assign q_job.temp_present = in_tuser[1];
  assign rd_data            = rd_data_r;

  always_ff @(posedge clk) begin
    if (acc && wr) begin
      store_r[cnt_r[IDX_W-1:0]] <= in_tdata[SAMPLE_W-1:0];
    end
    rd_data_r <= store_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (acc) begin
      if (in_tlast) begin
        cnt_r <= '0;
      end else if (wr) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

endmodule

@@ sv/mwc_back.sv @@
module mwc_back #(
  parameter int MAX_SAMPLES = mwc_pkg::DEF_MAX_SAMPLES
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  mwc_pkg::cfg_t                  cfg,
  input  logic                           q_empty,
  input  mwc_pkg::job_t                  q_head,
  output logic                           q_pop,
  output mwc_pkg::bk_stat_t              stat,
  output logic [$clog2(MAX_SAMPLES)-1:0] rd_addr,
  input  logic [mwc_pkg::SAMPLE_W-1:0]   rd_data,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [15:0]                    out_tdata,  // weight_cg
  output logic [2:0]                     out_tuser   // status, temp_applied
);
  import mwc_pkg::*;

  localparam int IDX_W = $clog2(MAX_SAMPLES);
  localparam int XH_W  = REM_W - UNIT_SH;

  typedef enum logic [3:0] {
    S_IDLE, S_CAND_ADDR, S_CAND_LD, S_CMP, S_SPREAD, S_MUL, S_DPREP,
    S_DIV, S_SUM, S_CGMUL, S_EMIT
  } state_t;

  state_t                      state_r;
  logic [CNT_W-1:0]            n_r;
  logic [IDX_W-1:0]            i_r;
  logic [IDX_W-1:0]            j_r;
  logic [CNT_W-1:0]            rank_r;
  logic signed [SAMPLE_W-1:0]  cand_r;
  logic signed [SAMPLE_W-1:0]  min_r;
  logic signed [SAMPLE_W-1:0]  max_r;
  logic signed [SAMPLE_W-1:0]  med_r;
  logic signed [TEMP_W-1:0]    temp_r;
  logic                        tp_r;
  logic                        tvalid_r;
  logic signed [16:0]          dt_r;
  logic signed [33:0]          prod_r;
  logic [REM_W-1:0]            rem_r;
  logic [Q_W-1:0]              q_r;
  logic [HELD_W-1:0]           held_r;
  logic [HELD_W-1:0]           wt_r;
  logic [1:0]                  status_r;
  logic                        tapp_r;
  logic [39:0]                 cg_prod_r;
  logic                        out_valid_r;
  logic [WCG_W-1:0]            out_cg_r;
  logic [1:0]                  out_status_r;
  logic                        out_tapp_r;

  logic signed [SAMPLE_W-1:0]  smp;
  logic                        less;
  logic [CNT_W-1:0]            rank_nxt;
  logic [CNT_W-1:0]            n_m1;
  logic                        last_j;
  logic                        last_i;
  logic [SAMPLE_W:0]           spread;
  logic                        spread_over;
  logic                        t_ok;
  logic signed [16:0]          dt;
  logic signed [33:0]          prod;
  logic signed [34:0]          d2;
  logic [REM_W+1:0]            x;
  logic [XH_W-1:0]             x_hi;
  logic [XH_W+29:0]            div_prod;
  logic signed [Q_W:0]         q_s;
  logic signed [SAMPLE_W:0]    m2;
  logic signed [SAMPLE_W+1:0]  sum;
  logic [HELD_W-1:0]           held_nxt;
  logic [19:0]                 wt_p5;
  logic                        few;
  logic                        emit;

  assign smp      = rd_data;
  // stable rank: equal samples order by position
  assign less     = (smp < cand_r) || ((smp == cand_r) && (j_r < i_r));
  assign rank_nxt = rank_r + CNT_W'(less);
  assign n_m1     = n_r - 1'b1;
  assign last_j   = (CNT_W'(j_r) == n_m1);
  assign last_i   = (CNT_W'(i_r) == n_m1);

  assign spread      = {max_r[SAMPLE_W-1], max_r} - {min_r[SAMPLE_W-1], min_r};
  assign spread_over = spread > {{(SAMPLE_W-15){1'b0}}, cfg.spread_limit};

  assign t_ok = tp_r && (temp_r > T_LOW) && (temp_r < T_HIGH);
  assign dt   = {temp_r[TEMP_W-1], temp_r} - {{2{cfg.cal_temp[14]}}, cfg.cal_temp};
  assign prod = $signed({1'b0, cfg.drift_mg}) * dt_r;

  // x = offset + half unit - drift, always positive and below UNIT_G << Q_W
  assign d2    = cfg.half_mode ? {prod_r, 1'b0} : {prod_r[33], prod_r};
  assign x     = DIV_BASE - {d2[34], d2};

  // floor(x / UNIT_G): drop the power of two, then multiply by the reciprocal of 3125
  assign x_hi     = rem_r[REM_W-1:UNIT_SH];
  assign div_prod = x_hi * RECIP3125;

  assign q_s = $signed({1'b0, q_r}) - (Q_W+1)'(Q_BIAS);
  assign m2  = cfg.half_mode ? {med_r, 1'b0} : {med_r[SAMPLE_W-1], med_r};
  assign sum = {m2[SAMPLE_W], m2} + (SAMPLE_W+2)'(q_s);

  always_comb begin
    if (sum[SAMPLE_W+1]) begin
      held_nxt = '0;
    end else if (sum > $signed({7'd0, W_MAX_G})) begin
      held_nxt = W_MAX_G;
    end else begin
      held_nxt = sum[HELD_W-1:0];
    end
  end

  assign wt_p5 = {1'b0, wt_r} + 20'd5;
  assign few   = (q_head.n == '0) || (q_head.n < CNT_W'(cfg.min_samples));

  always_comb begin
    case (state_r)
      S_CAND_ADDR: rd_addr = i_r;
      S_CMP:       rd_addr = last_j ? '0 : j_r + 1'b1;
      default:     rd_addr = '0;
    endcase
  end

  assign q_pop        = (state_r == S_IDLE) && !q_empty;
  assign stat.walking = (state_r == S_CAND_ADDR) || (state_r == S_CAND_LD) ||
                        (state_r == S_CMP);
  assign emit         = (state_r == S_EMIT) && (!out_valid_r || out_tready);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_cg_r};
  assign out_tuser  = {out_tapp_r, out_status_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            n_r    <= q_head.n;
            temp_r <= q_head.temp_x100;
            tp_r   <= q_head.temp_present;
            i_r    <= '0;
            j_r    <= '0;
            rank_r <= '0;
            if (few) begin
              wt_r     <= held_r;
              status_r <= (held_r == '0) ? ST_NONE : ST_FEW;
              tapp_r   <= 1'b0;
              state_r  <= S_CGMUL;
            end else begin
              state_r <= S_CAND_ADDR;
            end
          end
        end
        S_CAND_ADDR: begin
          state_r <= S_CAND_LD;
        end
        S_CAND_LD: begin
          cand_r  <= smp;
          j_r     <= '0;
          rank_r  <= '0;
          state_r <= S_CMP;
        end
        S_CMP: begin
          if (last_j) begin
            if (rank_nxt == '0) begin
              min_r <= cand_r;
            end
            if (rank_nxt == n_m1) begin
              max_r <= cand_r;
            end
            if (rank_nxt == (n_r >> 1)) begin
              med_r <= cand_r;
            end
            if (last_i) begin
              state_r <= S_SPREAD;
            end else begin
              i_r     <= i_r + 1'b1;
              state_r <= S_CAND_ADDR;
            end
          end else begin
            j_r    <= j_r + 1'b1;
            rank_r <= rank_nxt;
          end
        end
        S_SPREAD: begin
          if (spread_over) begin
            wt_r     <= held_r;
            status_r <= (held_r == '0) ? ST_NONE : ST_UNSTABLE;
            tapp_r   <= 1'b0;
            state_r  <= S_CGMUL;
          end else begin
            tvalid_r <= t_ok;
            dt_r     <= dt;
            state_r  <= S_MUL;
          end
        end
        S_MUL: begin
          prod_r  <= tvalid_r ? prod : '0;
          state_r <= S_DPREP;
        end
        S_DPREP: begin
          rem_r   <= x[REM_W-1:0];
          q_r     <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          q_r     <= div_prod[RECIP_SH +: Q_W];
          state_r <= S_SUM;
        end
        S_SUM: begin
          held_r   <= held_nxt;
          wt_r     <= held_nxt;
          status_r <= ST_FRESH;
          tapp_r   <= tvalid_r;
          state_r  <= S_CGMUL;
        end
        S_CGMUL: begin
          cg_prod_r <= wt_p5 * RECIP10;
          state_r   <= S_EMIT;
        end
        S_EMIT: begin
          if (emit) begin
            out_cg_r     <= cg_prod_r[RECIP10_SH +: WCG_W];
            out_status_r <= status_r;
            out_tapp_r   <= tapp_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ sv/median_weight_conditioner.sv @@
// samples are taken one per cycle while no job is queued and the sample store is free; a
// set's closing word yields one result word. the rank-counting walk over the store (one
// compare per cycle) finds the kept samples' median, minimum and maximum; a too-few set
// skips the walk. next set's words wait while the job is queued and the walk runs.
// rst_n is synchronous, active low: registers to defaults, held weight zero, set empty.
module median_weight_conditioner #(
  parameter int MAX_SAMPLES = mwc_pkg::DEF_MAX_SAMPLES
) (
  input  logic        clk,
  input  logic        rst_n,
  // sample words
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [23:0] sample_g, [39:24] temp_x100
  input  logic [1:0]  in_tuser,   // [0] sample_ok, [1] temp_present
  input  logic        in_tlast,   // last_sample
  // result words
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [14:0] weight_cg, [15] zero
  output logic [2:0]  out_tuser,  // [1:0] status, [2] temp_applied
  // register writes
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);
  import mwc_pkg::*;

  localparam int IDX_W = $clog2(MAX_SAMPLES);

  cfg_t                cfg_r;
  bk_stat_t            bk_stat;
  job_t                push_job;
  job_t                q_head;
  logic                q_push;
  logic                q_pop;
  logic                q_empty;
  logic [IDX_W-1:0]    rd_addr;
  logic [SAMPLE_W-1:0] rd_data;

  // config registers; the user must write them only while the block is idle, the block itself does not enforce it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.drift_mg     <= RST_DRIFT;
      cfg_r.cal_temp     <= RST_CAL_TEMP;
      cfg_r.spread_limit <= RST_SPREAD_LIM;
      cfg_r.min_samples  <= RST_MIN_SAMP;
      cfg_r.half_mode    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_DRIFT:      cfg_r.drift_mg     <= cfg_wdata;
        CFG_CAL_TEMP:   cfg_r.cal_temp     <= cfg_wdata[14:0];
        CFG_SPREAD_LIM: cfg_r.spread_limit <= cfg_wdata;
        CFG_MIN_SAMP:   cfg_r.min_samples  <= cfg_wdata[3:0];
        CFG_HALF_MODE:  cfg_r.half_mode    <= cfg_wdata[0];
        default:        cfg_r              <= cfg_r;
      endcase
    end
  end

  // front end: takes words, fills the sample store, queues a job per closed set
  mwc_front #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata (in_tdata),
    .in_tuser (in_tuser),
    .in_tlast (in_tlast),
    .stat     (bk_stat),
    .q_empty  (q_empty),
    .q_push   (q_push),
    .q_job    (push_job),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data)
  );

  // short job queue between the two halves
  mwc_jobq #(
    .DEPTH(JOBQ_DEPTH)
  ) u_jobq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_job(push_job),
    .pop     (q_pop),
    .head    (q_head),
    .empty   (q_empty)
  );

  // back end: median and spread by rank walk, compensation, rounding, output stage
  mwc_back #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .stat      (bk_stat),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  // the store walk never overlaps a pending job
  a_walk_alone: assert property (@(posedge clk) disable iff (!rst_n)
    bk_stat.walking |-> q_empty)
    else $error("job queued while the sample store is being walked");

  // clamp keeps the report within 320 kg
  a_weight_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[14:0] <= 15'd32000))
    else $error("reported weight above range");

  a_none_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser[1:0] == ST_NONE)) |-> (out_tdata[14:0] == '0))
    else $error("no-weight report carries a weight");

  a_temp_fresh: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[2]) |-> (out_tuser[1:0] == ST_FRESH))
    else $error("compensation flagged on a held report");

endmodule
